// File: rtl/ohmac_pkg.sv
// Shared types, register codes and range constants for the ohmmeter converter.
package ohmac_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RES_W    = 32;
    localparam int GAIN_W   = 32;
    localparam int OFFS_W   = 16;
    localparam int CAL_W    = GAIN_W + OFFS_W;
    localparam int THR_W    = 16;
    localparam int RANGES   = 4;
    localparam int RANGE_W  = 2;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;
    localparam int IDX_W    = 3;

    localparam logic [1:0] MODE_MANUAL     = 2'd0;
    localparam logic [1:0] MODE_AUTO       = 2'd1;
    localparam logic [1:0] MODE_CONTINUITY = 2'd2;

    localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [IDX_W-1:0] REG_MANUAL    = 3'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd2;
    localparam logic [IDX_W-1:0] REG_CAL0      = 3'd3;
    localparam logic [IDX_W-1:0] REG_CAL1      = 3'd4;
    localparam logic [IDX_W-1:0] REG_CAL2      = 3'd5;
    localparam logic [IDX_W-1:0] REG_CAL3      = 3'd6;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd1000;
    localparam logic [RANGE_W-1:0] AUTO_RANGE_RESET = 2'd1;
    localparam logic [RANGES-1:0][CAL_W-1:0] CAL_RESET = {
        48'd2162721036144, 48'd220012289676, 48'd16324891257, 48'd16324891257
    };

    localparam logic [RANGES-1:0][RES_W-1:0] RANGE_LIMIT = {
        32'd20000000, 32'd2000000, 32'd200000, 32'd20000
    };
    localparam logic [RANGES-1:0][RES_W-1:0] RANGE_LOWER = {
        32'd1700000, 32'd170000, 32'd17000, 32'd0
    };
    localparam logic [RANGES-1:0][RES_W-1:0] RANGE_UPPER = {
        32'd22000000, 32'd2200000, 32'd220000, 32'd22000
    };

    typedef struct packed {
        logic [1:0]                   mode;
        logic [RANGE_W-1:0]           manual_range;
        logic [THR_W-1:0]             threshold;
        logic [RANGES-1:0][CAL_W-1:0] cal;
    } ohmac_cfg_t;

    typedef struct packed {
        logic [RES_W-1:0]   resistance;
        logic               valid;
        logic [RANGE_W-1:0] range_used;
        logic [RANGE_W-1:0] range_next;
        logic               beep;
    } ohmac_result_t;

endpackage

// File: rtl/ohmac_regs.sv
// Configuration register file with APB-style access.
module ohmac_regs
    import ohmac_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output ohmac_cfg_t        cfg,
    output logic              auto_set
);

    ohmac_cfg_t       cfg_reg;
    ohmac_cfg_t       cfg_next;
    logic             write_en;
    logic [IDX_W-1:0] reg_index;

    assign pready    = 1'b1;
    assign write_en  = psel & penable & pwrite;
    assign reg_index = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign cfg       = cfg_reg;
    assign auto_set  = write_en && (reg_index == REG_MODE) && (pwdata[1:0] == MODE_AUTO);

    always_comb begin
        cfg_next = cfg_reg;
        if (write_en) begin
            case (reg_index)
                REG_MODE:      cfg_next.mode         = pwdata[1:0];
                REG_MANUAL:    cfg_next.manual_range = pwdata[RANGE_W-1:0];
                REG_THRESHOLD: cfg_next.threshold    = pwdata[THR_W-1:0];
                REG_CAL0:      cfg_next.cal[0]       = pwdata[CAL_W-1:0];
                REG_CAL1:      cfg_next.cal[1]       = pwdata[CAL_W-1:0];
                REG_CAL2:      cfg_next.cal[2]       = pwdata[CAL_W-1:0];
                REG_CAL3:      cfg_next.cal[3]       = pwdata[CAL_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode         <= MODE_MANUAL;
            cfg_reg.manual_range <= '0;
            cfg_reg.threshold    <= THRESHOLD_RESET;
            cfg_reg.cal          <= CAL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_index)
            REG_MODE:      prdata = {{(DATA_W-2){1'b0}}, cfg_reg.mode};
            REG_MANUAL:    prdata = {{(DATA_W-RANGE_W){1'b0}}, cfg_reg.manual_range};
            REG_THRESHOLD: prdata = {{(DATA_W-THR_W){1'b0}}, cfg_reg.threshold};
            REG_CAL0:      prdata = {{(DATA_W-CAL_W){1'b0}}, cfg_reg.cal[0]};
            REG_CAL1:      prdata = {{(DATA_W-CAL_W){1'b0}}, cfg_reg.cal[1]};
            REG_CAL2:      prdata = {{(DATA_W-CAL_W){1'b0}}, cfg_reg.cal[2]};
            REG_CAL3:      prdata = {{(DATA_W-CAL_W){1'b0}}, cfg_reg.cal[3]};
            default:       prdata = '0;
        endcase
    end

endmodule

// File: rtl/ohmac_core.sv
// Sample conversion, autorange decision and auto range state.
module ohmac_core
    import ohmac_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ohmac_cfg_t          cfg,
    input  logic                auto_set,
    input  logic                fire,
    input  logic [SAMPLE_W-1:0] sample,
    output ohmac_result_t       result
);

    logic [RANGE_W-1:0]        auto_range_reg;
    logic [RANGE_W-1:0]        auto_range_next;
    logic [RANGE_W-1:0]        used;
    logic [RANGE_W-1:0]        fitted;
    logic [CAL_W-1:0]          cal;
    logic [GAIN_W-1:0]         gain;
    logic [OFFS_W-1:0]         offset;
    logic [SAMPLE_W+GAIN_W-1:0] product;
    logic [RES_W-1:0]          scaled;
    logic [RES_W-1:0]          res;
    logic                      valid;
    logic                      out_of_band;

    always_comb begin
        case (cfg.mode)
            MODE_AUTO:       used = auto_range_reg;
            MODE_CONTINUITY: used = '0;
            default:         used = cfg.manual_range;
        endcase
    end

    assign valid   = (sample != '0) && (sample != '1);
    assign cal     = cfg.cal[used];
    assign gain    = cal[CAL_W-1:OFFS_W];
    assign offset  = cal[OFFS_W-1:0];
    assign product = (SAMPLE_W+GAIN_W)'(sample) * (SAMPLE_W+GAIN_W)'(gain);
    assign scaled  = product[SAMPLE_W+GAIN_W-1:SAMPLE_W];

    always_comb begin
        if (!valid || scaled <= RES_W'(offset)) begin
            res = '0;
        end else begin
            res = scaled - RES_W'(offset);
        end
    end

    always_comb begin
        if (res <= RANGE_LIMIT[0]) begin
            fitted = 2'd0;
        end else if (res <= RANGE_LIMIT[1]) begin
            fitted = 2'd1;
        end else if (res <= RANGE_LIMIT[2]) begin
            fitted = 2'd2;
        end else begin
            fitted = 2'd3;
        end
    end

    assign out_of_band = (res < RANGE_LOWER[used]) || (res > RANGE_UPPER[used]);

    always_comb begin
        result.resistance = res;
        result.valid      = valid;
        result.range_used = used;
        result.range_next = used;
        if (cfg.mode == MODE_AUTO && valid && out_of_band) begin
            result.range_next = fitted;
        end
        result.beep = (cfg.mode == MODE_CONTINUITY) && valid
                      && (res < RES_W'(cfg.threshold));
    end

    always_comb begin
        auto_range_next = auto_range_reg;
        if (auto_set) begin
            auto_range_next = AUTO_RANGE_RESET;
        end else if (fire && cfg.mode == MODE_AUTO) begin
            auto_range_next = result.range_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_range_reg <= AUTO_RANGE_RESET;
        end else begin
            auto_range_reg <= auto_range_next;
        end
    end

endmodule

// File: rtl/ohmmeter_autorange_converter_unit.sv
// Top level: autoranging ohmmeter converter with input and result registers.
// Pipeline: sample_reg holds an accepted input, out_reg its result on m_valid.
// Throughput: 1 transaction per cycle unless m_ready stalls; the multiply,
// offset subtract and range decision are combinational, so the auto range
// feeds the very next sample. Reset: aresetn synchronous, active low; clears
// both stages, loads register defaults and sets the auto range to the 2k range.
module ohmmeter_autorange_converter_unit
    import ohmac_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_adc_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [RES_W-1:0]    m_resistance_centiohm,
    output logic                m_reading_valid,
    output logic [RANGE_W-1:0]  m_range_used,
    output logic [RANGE_W-1:0]  m_range_next,
    output logic                m_continuity_beep
);

    ohmac_cfg_t          cfg;
    logic                auto_set;
    ohmac_result_t       result;
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    ohmac_result_t       out_reg;
    logic                advance;
    logic                fire;

    ohmac_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .auto_set (auto_set)
    );

    ohmac_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .auto_set (auto_set),
        .fire     (fire),
        .sample   (sample_reg),
        .result   (result)
    );

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_adc_sample;
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_resistance_centiohm = out_reg.resistance;
    assign m_reading_valid       = out_reg.valid;
    assign m_range_used          = out_reg.range_used;
    assign m_range_next          = out_reg.range_next;
    assign m_continuity_beep     = out_reg.beep;

endmodule

// File: sim/ohmmeter_autorange_converter_unit_tb.sv
// Self-checking testbench for the autoranging ohmmeter converter: directed table, random phases.
`timescale 1ns / 100ps

module ohmmeter_autorange_converter_unit_tb;
    import ohmac_pkg::*;

    localparam int RANDOM_ITEMS   = 1300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 4;

    localparam logic [1:0]       MODE_SPARE   = 2'd3;
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

    localparam logic [RANGES-1:0][CAL_W-1:0] CAL_DEFAULT = {
        48'd2162721036144, 48'd220012289676, 48'd16324891257, 48'd16324891257
    };
    localparam logic [RANGES-1:0][RES_W-1:0] SPAN_LIMIT = {
        32'd20000000, 32'd2000000, 32'd200000, 32'd20000
    };
    localparam logic [RANGES-1:0][RES_W-1:0] HYST_LOW = {
        32'd1700000, 32'd170000, 32'd17000, 32'd0
    };
    localparam logic [RANGES-1:0][RES_W-1:0] HYST_HIGH = {
        32'd22000000, 32'd2200000, 32'd220000, 32'd22000
    };

    typedef struct packed {
        logic               is_cfg;
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  value;
        logic [SAMPLE_W-1:0] sample;
        logic               has_exp;
        ohmac_result_t      exp;
    } bench_step_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_adc_sample = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [RES_W-1:0]    m_resistance_centiohm;
    logic                m_reading_valid;
    logic [RANGE_W-1:0]  m_range_used;
    logic [RANGE_W-1:0]  m_range_next;
    logic                m_continuity_beep;

    logic [1:0]                   shadow_mode       = MODE_MANUAL;
    logic [RANGE_W-1:0]           shadow_manual     = '0;
    logic [THR_W-1:0]             shadow_threshold  = 16'd1000;
    logic [RANGES-1:0][CAL_W-1:0] shadow_cal        = CAL_DEFAULT;
    logic [RANGE_W-1:0]           shadow_auto_range = 2'd1;

    ohmac_result_t pending_readings[$];
    ohmac_result_t want;
    bit            steady = 1'b0;
    int            err_count = 0;
    int            readings_checked = 0;
    int            items_sent = 0;
    int            writes_done = 0;
    int            range_moves = 0;
    int            mode_hits[4] = '{0, 0, 0, 0};
    int            stall_cycles = 0;
    logic [SAMPLE_W-1:0] hold_sample = 16'd2000;

    ohmmeter_autorange_converter_unit u_top (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_adc_sample          (s_adc_sample),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_resistance_centiohm (m_resistance_centiohm),
        .m_reading_valid       (m_reading_valid),
        .m_range_used          (m_range_used),
        .m_range_next          (m_range_next),
        .m_continuity_beep     (m_continuity_beep)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic ohmac_result_t predict_reading(input logic [SAMPLE_W-1:0] smp);
        ohmac_result_t      r;
        logic [RANGE_W-1:0] used;
        logic [63:0]        scaled;
        logic [63:0]        offs;
        r = '0;
        r.valid = (smp != '0) && (smp != '1);
        case (shadow_mode)
            MODE_AUTO:       used = shadow_auto_range;
            MODE_CONTINUITY: used = '0;
            default:         used = shadow_manual;
        endcase
        mode_hits[shadow_mode]++;
        if (r.valid) begin
            scaled = (64'(smp) * 64'(shadow_cal[used][CAL_W-1:OFFS_W])) >> 16;
            offs = 64'(shadow_cal[used][OFFS_W-1:0]);
            r.resistance = (scaled > offs) ? RES_W'(scaled - offs) : '0;
        end
        r.range_used = used;
        r.range_next = used;
        if (shadow_mode == MODE_AUTO && r.valid &&
            (r.resistance < HYST_LOW[used] || r.resistance > HYST_HIGH[used])) begin
            if (r.resistance <= SPAN_LIMIT[0]) r.range_next = 2'd0;
            else if (r.resistance <= SPAN_LIMIT[1]) r.range_next = 2'd1;
            else if (r.resistance <= SPAN_LIMIT[2]) r.range_next = 2'd2;
            else r.range_next = 2'd3;
            shadow_auto_range = r.range_next;
            range_moves++;
        end
        r.beep = (shadow_mode == MODE_CONTINUITY) && r.valid &&
                 (r.resistance < RES_W'(shadow_threshold));
        return r;
    endfunction

    function automatic bench_step_t cfg_row(input logic [IDX_W-1:0] idx,
                                            input logic [DATA_W-1:0] val);
        bench_step_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.value = val;
        return s;
    endfunction

    function automatic bench_step_t smp_row(input logic [SAMPLE_W-1:0] smp);
        bench_step_t s;
        s = '0;
        s.sample = smp;
        return s;
    endfunction

    function automatic bench_step_t chk_row(input logic [SAMPLE_W-1:0] smp,
                                            input logic [RES_W-1:0] res, input logic v,
                                            input logic [RANGE_W-1:0] used,
                                            input logic [RANGE_W-1:0] nxt, input logic bp);
        bench_step_t s;
        s = '0;
        s.sample = smp;
        s.has_exp = 1'b1;
        s.exp.resistance = res;
        s.exp.valid = v;
        s.exp.range_used = used;
        s.exp.range_next = nxt;
        s.exp.beep = bp;
        return s;
    endfunction

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] expd);
        $display("reading %0d: %s got 0x%0h, expected 0x%0h",
                 readings_checked, field, got, expd);
        err_count++;
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE: begin
                shadow_mode = val[1:0];
                if (val[1:0] == MODE_AUTO) shadow_auto_range = 2'd1;
            end
            REG_MANUAL:    shadow_manual = val[RANGE_W-1:0];
            REG_THRESHOLD: shadow_threshold = val[THR_W-1:0];
            REG_CAL0, REG_CAL1, REG_CAL2, REG_CAL3:
                shadow_cal[RANGE_W'(idx - REG_CAL0)] = val[CAL_W-1:0];
            default: ;
        endcase
        writes_done++;
        @(posedge aclk);
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic typed,
                               input ohmac_result_t typed_exp);
        ohmac_result_t pred;
        while (!steady && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_adc_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = predict_reading(smp);
        pending_readings.push_back(typed ? typed_exp : pred);
        items_sent++;
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) m_ready <= steady || ($urandom_range(99) >= 9);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                flag_mismatch("transaction with nothing outstanding",
                              m_resistance_centiohm, 0);
            end else begin
                want = pending_readings.pop_front();
                if (m_resistance_centiohm !== want.resistance)
                    flag_mismatch("resistance_centiohm", m_resistance_centiohm, want.resistance);
                if (m_reading_valid !== want.valid)
                    flag_mismatch("reading_valid", m_reading_valid, want.valid);
                if (m_range_used !== want.range_used)
                    flag_mismatch("range_used", m_range_used, want.range_used);
                if (m_range_next !== want.range_next)
                    flag_mismatch("range_next", m_range_next, want.range_next);
                if (m_continuity_beep !== want.beep)
                    flag_mismatch("continuity_beep", m_continuity_beep, want.beep);
            end
            readings_checked++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d readings outstanding",
                     stall_cycles, pending_readings.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        bench_step_t         plan[$];
        logic [CAL_W-1:0]    c;
        logic [1:0]          m;
        logic [SAMPLE_W-1:0] smp;
        int                  k;
        int                  j;
        int                  n;
        int                  phase;
        int                  random_sent;

        plan.push_back(chk_row(16'd0,     0, 1'b0, 2'd0, 2'd0, 1'b0));
        plan.push_back(chk_row(16'hFFFF,  0, 1'b0, 2'd0, 2'd0, 1'b0));
        plan.push_back(chk_row(16'd1,     0, 1'b1, 2'd0, 2'd0, 1'b0));
        plan.push_back(smp_row(16'hFFFE));
        plan.push_back(smp_row(16'h5555));
        plan.push_back(smp_row(16'hAAAA));
        plan.push_back(cfg_row(REG_MODE, 64'(MODE_CONTINUITY)));
        plan.push_back(chk_row(16'd1,     0, 1'b1, 2'd0, 2'd0, 1'b1));
        plan.push_back(chk_row(16'hFFFF,  0, 1'b0, 2'd0, 2'd0, 1'b0));
        plan.push_back(smp_row(16'd300));
        plan.push_back(cfg_row(REG_THRESHOLD, 64'd0));
        plan.push_back(chk_row(16'd1,     0, 1'b1, 2'd0, 2'd0, 1'b0));
        plan.push_back(cfg_row(REG_THRESHOLD, 64'd65535));
        plan.push_back(smp_row(16'd400));
        plan.push_back(cfg_row(REG_MODE, 64'(MODE_AUTO)));
        plan.push_back(chk_row(16'd0,     0, 1'b0, 2'd1, 2'd1, 1'b0));
        plan.push_back(chk_row(16'd1,     0, 1'b1, 2'd1, 2'd0, 1'b0));
        plan.push_back(smp_row(16'hFFFE));
        plan.push_back(smp_row(16'd30000));
        plan.push_back(smp_row(16'hFFFE));
        plan.push_back(cfg_row(REG_MODE, 64'(MODE_SPARE)));
        plan.push_back(cfg_row(REG_MANUAL, 64'd3));
        plan.push_back(smp_row(16'hFFFE));
        plan.push_back(cfg_row(REG_CAL3, 64'hFFFF_FFFF_FFFF));
        plan.push_back(smp_row(16'hFFFE));
        plan.push_back(chk_row(16'd1,     0, 1'b1, 2'd3, 2'd3, 1'b0));
        plan.push_back(cfg_row(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(cfg_row(REG_CAL0, 64'd0));
        plan.push_back(cfg_row(REG_MODE, 64'(MODE_CONTINUITY)));
        plan.push_back(chk_row(16'd40000, 0, 1'b1, 2'd0, 2'd0, 1'b1));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_drain();
                reg_write(plan[i].idx, plan[i].value);
            end else begin
                push_sample(plan[i].sample, plan[i].has_exp, plan[i].exp);
            end
        end

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_drain();
            k = $urandom_range(9);
            m = (k < 2) ? MODE_MANUAL : (k < 6) ? MODE_AUTO :
                (k < 8) ? MODE_CONTINUITY : MODE_SPARE;
            if (phase == 0 || $urandom_range(3) != 0) reg_write(REG_MODE, 64'(m));
            if (phase == 0 || $urandom_range(1) != 0)
                reg_write(REG_MANUAL, 64'($urandom_range(3)));
            if (phase == 0 || $urandom_range(1) != 0) begin
                case ($urandom_range(3))
                    0:       reg_write(REG_THRESHOLD, 64'd0);
                    1:       reg_write(REG_THRESHOLD, 64'd65535);
                    2:       reg_write(REG_THRESHOLD, 64'($urandom_range(3000)));
                    default: reg_write(REG_THRESHOLD, 64'($urandom_range(65535)));
                endcase
            end
            for (int r = 0; r < RANGES; r++) begin
                if (phase == 0 || $urandom_range(3) == 0) begin
                    case ($urandom_range(5))
                        0, 1:    c = CAL_DEFAULT[r];
                        2:       c = {$urandom, 16'($urandom)};
                        3:       c = '0;
                        4:       c = '1;
                        default: c = {CAL_DEFAULT[r][CAL_W-1:OFFS_W], 16'($urandom)};
                    endcase
                    reg_write(IDX_W'(REG_CAL0 + r), 64'(c));
                end
            end
            if ($urandom_range(7) == 0) reg_write(REG_UNMAPPED, {$urandom, $urandom});

            steady = (phase >= 8 && phase < 12);
            n = steady ? 80 : $urandom_range(10, 70);
            repeat (n) begin
                k = $urandom_range(99);
                if (k < 4) begin
                    smp = '0;
                end else if (k < 8) begin
                    smp = '1;
                end else if (k < 12) begin
                    smp = 16'($urandom_range(1, 255));
                end else if (k < 16) begin
                    smp = 16'($urandom_range(65280, 65534));
                end else if (k < 40) begin
                    smp = 16'($urandom_range(65535));
                end else begin
                    if ($urandom_range(9) == 0) hold_sample = 16'($urandom_range(1, 65534));
                    j = int'(hold_sample) + $urandom_range(128) - 64;
                    if (j < 1) j = 1;
                    if (j > 65534) j = 65534;
                    smp = 16'(j);
                end
                push_sample(smp, 1'b0, '0);
                random_sent++;
            end
            phase++;
        end

        wait_drain();
        $display("Checked %0d readings from %0d samples over %0d settings, %0d register writes",
                 readings_checked, items_sent, phase, writes_done);
        $display("Per mode: manual %0d, auto %0d, continuity %0d, spare %0d; range moves %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], range_moves);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/ohmac_pkg.sv
rtl/ohmac_regs.sv
rtl/ohmac_core.sv
rtl/ohmmeter_autorange_converter_unit.sv
sim/ohmmeter_autorange_converter_unit_tb.sv
